// ===== rtl/core/sfla_pkg.sv =====
package sfla_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int REGION_PAGES = 16;
	localparam int ADDR_SPACE   = 65536;

	localparam int ADDR_W   = 16;
	localparam int LINK_AW  = 13;
	localparam int CFG_W    = 13;
	localparam int SLOT_W   = 14;
	localparam int SPAN_W   = 18;
	localparam int FRAME_W  = 4;
	localparam int LIVE_W   = 14;
	localparam int PAGES_W  = 4;
	localparam int STATUS_W = 2;

	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
	localparam logic [SLOT_W-1:0]  MIN_SLOT  = SLOT_W'(8);
	localparam logic [LIVE_W-1:0]  LIVE_MAX  = LIVE_W'(16383);
	localparam logic [PAGES_W-1:0] PAGES_MAX = PAGES_W'(15);

	localparam logic [STATUS_W-1:0] ST_ALLOC_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FREED      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NULL_FREE  = 2'd3;

	typedef struct packed {
		logic               wr_en;
		logic               rd_en;
		logic [LINK_AW-1:0] addr;
		logic [ADDR_W-1:0]  wdata;
	} link_req_t;

	function automatic logic frame_ok(logic [FRAME_W-1:0] f);
		int fi;
		fi = int'(f);
		return (fi != 0) && (fi < REGION_PAGES) && ((fi + 1) * PAGE_BYTES <= ADDR_SPACE);
	endfunction

	function automatic logic [ADDR_W-1:0] frame_base(logic [FRAME_W-1:0] f);
		int prod;
		prod = int'(f) * PAGE_BYTES;
		return ADDR_W'(prod);
	endfunction

endpackage

// ===== rtl/core/sfla_link_ram.sv =====
module sfla_link_ram (
	input  logic                      clk,
	input  sfla_pkg::link_req_t       req,
	output logic [sfla_pkg::ADDR_W-1:0] rdata
);
	import sfla_pkg::*;

	logic [ADDR_W-1:0] mem [2**LINK_AW];
	logic [ADDR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sfla_ctrl.sv =====
module sfla_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [sfla_pkg::ADDR_W-1:0]   free_address,
	input  logic [sfla_pkg::FRAME_W-1:0]  offered_frame,
	input  logic [sfla_pkg::SLOT_W-1:0]   slot_bytes,
	output sfla_pkg::link_req_t           link_req,
	input  logic [sfla_pkg::ADDR_W-1:0]   link_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sfla_pkg::STATUS_W-1:0] status,
	output logic [sfla_pkg::ADDR_W-1:0]   object_address,
	output logic                          frame_taken,
	output logic [sfla_pkg::LIVE_W-1:0]   allocated_count,
	output logic [sfla_pkg::PAGES_W-1:0]  page_count
);
	import sfla_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_GROW   = 2'd2;
	localparam logic [1:0] S_POP    = 2'd3;

	logic [1:0]          state_q;
	logic                cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [ADDR_W-1:0]   head_q;
	logic [LIVE_W-1:0]   live_q;
	logic [PAGES_W-1:0]  pages_q;
	logic [SPAN_W-1:0]   off_q;
	logic [ADDR_W-1:0]   base_q;
	logic                taken_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   obj_q;
	logic                frame_taken_q;

	logic                out_free;
	logic                accept;
	logic                result_fire;
	logic [SPAN_W-1:0]   slot_ext;
	logic                grow_ok;
	logic [ADDR_W-1:0]   carve_addr;
	logic [SPAN_W-1:0]   next_off;
	logic                last_slot;
	logic [LIVE_W-1:0]   live_inc;
	logic [LIVE_W-1:0]   live_dec;
	logic [PAGES_W-1:0]  pages_inc;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign slot_ext   = SPAN_W'(slot_bytes);
	assign grow_ok    = frame_ok(frame_q) && (slot_ext <= SPAN_W'(PAGE_BYTES));
	assign carve_addr = base_q + ADDR_W'(off_q);
	assign next_off   = off_q + slot_ext;
	assign last_slot  = (next_off + slot_ext) > SPAN_W'(PAGE_BYTES);
	assign live_inc   = (live_q == LIVE_MAX) ? live_q : live_q + LIVE_W'(1);
	assign live_dec   = (live_q == '0) ? live_q : live_q - LIVE_W'(1);
	assign pages_inc  = (pages_q == PAGES_MAX) ? pages_q : pages_q + PAGES_W'(1);
	assign result_fire = out_free && (((state_q == S_DECIDE)
		&& (cmd_q || (head_q == '0 && !grow_ok))) || (state_q == S_POP));

	always_comb begin
		link_req = '0;
		unique case (state_q)
			S_DECIDE: begin
				if (!cmd_q && head_q != '0) begin
					link_req.rd_en = 1'b1;
					link_req.addr  = head_q[ADDR_W-1:3];
				end else if (cmd_q && addr_q != '0 && out_free) begin
					link_req.wr_en = 1'b1;
					link_req.addr  = addr_q[ADDR_W-1:3];
					link_req.wdata = head_q;
				end
			end
			S_GROW: begin
				link_req.wr_en = 1'b1;
				link_req.addr  = carve_addr[ADDR_W-1:3];
				link_req.wdata = head_q;
			end
			default: begin
				link_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			live_q      <= '0;
			pages_q     <= '0;
			taken_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= result_fire || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						taken_q <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!cmd_q) begin
						if (head_q != '0) begin
							state_q <= S_POP;
						end else if (grow_ok) begin
							if (out_free) begin
								state_q <= S_GROW;
							end
						end else if (out_free) begin
							state_q <= S_IDLE;
						end
					end else if (out_free) begin
						if (addr_q != '0) begin
							head_q <= addr_q;
							live_q <= live_dec;
						end
						state_q <= S_IDLE;
					end
				end
				S_GROW: begin
					head_q <= carve_addr;
					if (last_slot) begin
						pages_q <= pages_inc;
						taken_q <= 1'b1;
						state_q <= S_DECIDE;
					end
				end
				S_POP: begin
					if (out_free) begin
						head_q  <= link_rdata;
						live_q  <= live_inc;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			addr_q  <= free_address;
			frame_q <= offered_frame;
		end
		if (state_q == S_DECIDE) begin
			off_q  <= '0;
			base_q <= frame_base(frame_q);
			if (out_free) begin
				obj_q         <= '0;
				frame_taken_q <= 1'b0;
				if (!cmd_q) begin
					status_q <= ST_ALLOC_FAIL;
				end else if (addr_q == '0) begin
					status_q <= ST_NULL_FREE;
				end else begin
					status_q <= ST_FREED;
				end
			end
		end
		if (state_q == S_GROW) begin
			off_q <= next_off;
		end
		if (state_q == S_POP && out_free) begin
			status_q      <= ST_ALLOC_OK;
			obj_q         <= head_q;
			frame_taken_q <= taken_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign object_address  = obj_q;
	assign frame_taken     = frame_taken_q;
	assign allocated_count = live_q;
	assign page_count      = pages_q;

endmodule

// ===== rtl/core/slab_free_list_allocator.sv =====
// A free or a failed alloc gives its result from the decide state; an alloc from a
// non-empty list gives it from the pop state, through one read of the link memory.
// An alloc that finds the list empty carves the offered page first, one link-memory write
// per slot; carving waits for a held result beat.
// One item is in flight at a time: the input stalls until the item's result is issued.
// Reset clears the list head, the counts and the object size (to 8); the link memory is not
// cleared and needs no clearing pass.
module slab_free_list_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfla_pkg::CFG_W-1:0]    object_size_request,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [sfla_pkg::ADDR_W-1:0]   free_address,
	input  logic [sfla_pkg::FRAME_W-1:0]  offered_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sfla_pkg::STATUS_W-1:0] status,
	output logic [sfla_pkg::ADDR_W-1:0]   object_address,
	output logic                          frame_taken,
	output logic [sfla_pkg::LIVE_W-1:0]   allocated_count,
	output logic [sfla_pkg::PAGES_W-1:0]  page_count
);
	import sfla_pkg::*;

	logic [CFG_W-1:0]  size_q;
	logic [SLOT_W-1:0] size_ext;
	logic [SLOT_W-1:0] size_clamped;
	logic [SLOT_W-1:0] slot_bytes;
	link_req_t         link_req;
	logic [ADDR_W-1:0] link_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= object_size_request;
		end
	end

	assign size_ext     = SLOT_W'(size_q);
	assign size_clamped = (size_ext < MIN_SLOT) ? MIN_SLOT : size_ext;
	assign slot_bytes   = (size_clamped + SLOT_W'(7)) & ~SLOT_W'(7);

	sfla_link_ram u_link_ram (
		.clk   (clk),
		.req   (link_req),
		.rdata (link_rdata)
	);

	sfla_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.free_address    (free_address),
		.offered_frame   (offered_frame),
		.slot_bytes      (slot_bytes),
		.link_req        (link_req),
		.link_rdata      (link_rdata),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.object_address  (object_address),
		.frame_taken     (frame_taken),
		.allocated_count (allocated_count),
		.page_count      (page_count)
	);

endmodule

// ===== rtl/core/sfla_checker.sv =====
module sfla_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sfla_pkg::STATUS_W-1:0] status,
	input logic [sfla_pkg::ADDR_W-1:0]   object_address,
	input logic                          frame_taken
);
	import sfla_pkg::*;

	// A held result beat keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(object_address))
		else $error("stalled result beat changed");

	// Only a successful alloc carries an address.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ALLOC_OK |-> object_address == '0 && !frame_taken)
		else $error("address or frame flag on a result that is not an alloc");

	// A successful alloc never hands out the null address.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ALLOC_OK |-> object_address != '0)
		else $error("alloc returned the null address");

	// One item at a time: the input stalls right after a beat is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in flight");

endmodule

bind slab_free_list_allocator sfla_checker u_sfla_checker (.*);

// ===== tb/tb_slab_free_list_allocator.sv =====
module tb_slab_free_list_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import sfla_pkg::*;

	localparam logic CMD_ALLOC  = 1'b0;
	localparam logic CMD_FREE   = 1'b1;
	localparam int   LINK_DEPTH = 1 << LINK_AW;
	localparam int   PHASES     = 10;
	localparam int   PHASE_BEATS = 63;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   object_address;
		logic                frame_taken;
		logic [LIVE_W-1:0]   allocated_count;
		logic [PAGES_W-1:0]  page_count;
	} slab_result_t;

	class slab_mirror;
		int unsigned       size_req;
		logic [ADDR_W-1:0] head;
		logic [ADDR_W-1:0] links [LINK_DEPTH];
		int unsigned       live;
		int unsigned       pages;
		int unsigned       mismatches;
		slab_result_t      pending [$];

		function new();
			size_req   = CFG_RESET;
			head       = '0;
			live       = 0;
			pages      = 0;
			mismatches = 0;
		endfunction

		function void set_size(int unsigned v);
			size_req = v;
		endfunction

		function void push_slot(logic [ADDR_W-1:0] a);
			links[int'(a >> 3)] = head;
			head = a;
		endfunction

		function bit carve(logic [FRAME_W-1:0] frame);
			int unsigned slot;
			int unsigned per_page;
			int unsigned base;
			slot = (size_req < MIN_SLOT) ? MIN_SLOT : size_req;
			slot = (slot + 7) & 32'hFFFF_FFF8;
			per_page = PAGE_BYTES / slot;
			base = int'(frame) * PAGE_BYTES;
			if (frame == 0 || frame >= REGION_PAGES || base + PAGE_BYTES > ADDR_SPACE
					|| per_page == 0)
				return 1'b0;
			for (int unsigned i = 0; i < per_page; i++)
				push_slot(ADDR_W'(base + i * slot));
			if (pages < PAGES_MAX)
				pages++;
			return 1'b1;
		endfunction

		function slab_result_t note_request(logic c, logic [ADDR_W-1:0] fa,
				logic [FRAME_W-1:0] fr);
			slab_result_t r;
			bit ok;
			r = '0;
			if (c == CMD_ALLOC) begin
				ok = 1'b1;
				if (head == 0) begin
					ok = carve(fr);
					r.frame_taken = ok;
				end
				if (ok) begin
					r.object_address = head;
					head = links[int'(head >> 3)];
					if (live < LIVE_MAX)
						live++;
					r.status = ST_ALLOC_OK;
				end else begin
					r.status = ST_ALLOC_FAIL;
				end
			end else if (fa == 0) begin
				r.status = ST_NULL_FREE;
			end else begin
				push_slot(fa);
				if (live > 0)
					live--;
				r.status = ST_FREED;
			end
			r.allocated_count = LIVE_W'(live);
			r.page_count = PAGES_W'(pages);
			pending.push_back(r);
			return r;
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(slab_result_t got);
			slab_result_t want;
			if (pending.size() == 0) begin
				$error("result beat with no request outstanding: %p", got);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			check_field("status", want.status, got.status);
			check_field("object_address", want.object_address, got.object_address);
			check_field("frame_taken", want.frame_taken, got.frame_taken);
			check_field("allocated_count", want.allocated_count, got.allocated_count);
			check_field("page_count", want.page_count, got.page_count);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     object_size_request = CFG_RESET;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 cmd = CMD_ALLOC;
	logic [ADDR_W-1:0]    free_address = '0;
	logic [FRAME_W-1:0]   offered_frame = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [ADDR_W-1:0]    object_address;
	logic                 frame_taken;
	logic [LIVE_W-1:0]    allocated_count;
	logic [PAGES_W-1:0]   page_count;

	slab_mirror        mirror;
	logic [ADDR_W-1:0] held [$];
	bit                calm = 1'b0;
	int unsigned       out_hold = 0;
	int unsigned       phase_sizes [PHASES];

	slab_free_list_allocator dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.object_size_request(object_size_request),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.cmd                (cmd),
		.free_address       (free_address),
		.offered_frame      (offered_frame),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.object_address     (object_address),
		.frame_taken        (frame_taken),
		.allocated_count    (allocated_count),
		.page_count         (page_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The stall drawn after each result beat counts down whether or not a result is waiting.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			mirror.check_result({status, object_address, frame_taken, allocated_count,
				page_count});
			out_hold = calm ? 0 : $urandom_range(0, 11);
		end else if (out_hold != 0) begin
			out_hold--;
		end
		out_stall <= (out_hold != 0);
	end

	task automatic send_item(input logic c, input logic [ADDR_W-1:0] fa,
			input logic [FRAME_W-1:0] fr);
		int unsigned gap;
		slab_result_t want;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		free_address <= fa;
		offered_frame <= fr;
		do @(posedge clk); while (in_stall);
		want = mirror.note_request(c, fa, fr);
		if (c == CMD_ALLOC && want.status == ST_ALLOC_OK)
			held.push_back(want.object_address);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.pending.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input int unsigned v);
		settle();
		cfg_valid <= 1'b1;
		object_size_request <= CFG_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mirror.set_size(v);
	endtask

	task automatic random_item();
		int unsigned pick;
		int unsigned idx;
		logic [ADDR_W-1:0] a;
		logic [FRAME_W-1:0] fr;
		pick = $urandom_range(0, 99);
		fr = ($urandom_range(0, 9) == 0) ? '0 : FRAME_W'($urandom_range(1, 15));
		if (pick < 50) begin
			send_item(CMD_ALLOC, ADDR_W'($urandom), fr);
		end else if (pick < 80 && held.size() != 0) begin
			idx = $urandom_range(0, held.size() - 1);
			a = held[idx];
			held.delete(idx);
			send_item(CMD_FREE, a, fr);
		end else if (pick < 88) begin
			send_item(CMD_FREE, '0, fr);
		end else begin
			send_item(CMD_FREE, ADDR_W'($urandom), fr);
		end
	endtask

	initial begin
		int unsigned spins;
		mirror = new();
		phase_sizes = '{8, 1, 4096, 8191, 24, 0, 2049, 4095, 0, 0};
		phase_sizes[8] = $urandom_range(1, 4096);
		phase_sizes[9] = $urandom_range(0, 8191);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Null free, a free with nothing live, then a pop and an empty list with no frame.
		send_item(CMD_FREE, '0, 4'hF);
		send_item(CMD_FREE, 16'h0008, 4'h0);
		send_item(CMD_ALLOC, 16'h0000, 4'h0);
		send_item(CMD_ALLOC, 16'hFFFF, 4'h0);
		// A slot larger than a page cannot be carved, so the frame is left alone.
		write_size(8191);
		send_item(CMD_ALLOC, 16'h0000, 4'h7);
		write_size(4096);
		send_item(CMD_ALLOC, 16'h0000, 4'h1);
		send_item(CMD_ALLOC, 16'h0000, 4'h0);
		send_item(CMD_ALLOC, 16'h0000, 4'hF);
		send_item(CMD_FREE, 16'hFFFF, 4'h0);
		send_item(CMD_ALLOC, 16'h0000, 4'h0);
		write_size(1);
		send_item(CMD_ALLOC, 16'h0000, 4'hE);
		send_item(CMD_ALLOC, 16'hFFFF, 4'h0);
		send_item(CMD_FREE, 16'h1000, 4'hF);
		send_item(CMD_ALLOC, 16'h0000, 4'h0);
		send_item(CMD_FREE, 16'hF000, 4'h0);
		send_item(CMD_FREE, 16'h7FFB, 4'h0);
		send_item(CMD_ALLOC, 16'h0000, 4'h0);
		held.delete();

		for (int p = 0; p < PHASES; p++) begin
			write_size(phase_sizes[p]);
			calm = ($urandom_range(0, 3) == 0);
			repeat (PHASE_BEATS) random_item();
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		spins = 0;
		while (mirror.pending.size() != 0 && spins < 50000) begin
			@(posedge clk);
			spins++;
		end
		repeat (20) @(posedge clk);
		if (mirror.pending.size() != 0)
			$error("%0d expected results never arrived", mirror.pending.size());
		if (mirror.mismatches == 0 && mirror.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sfla_pkg.sv
rtl/core/sfla_link_ram.sv
rtl/core/sfla_ctrl.sv
rtl/core/slab_free_list_allocator.sv
rtl/core/sfla_checker.sv
tb/tb_slab_free_list_allocator.sv
